>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the geometry, the command and result item layouts, and the decoded command kinds.
// No dependencies.
package tcw_pkg;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam int IDX_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam int PADDR_W = 3;

  localparam logic REG_BLANK_ATTR = 1'b0;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] BLANK_ATTR_RESET = 8'd7;

  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_COLOR  = 3'd1;
  localparam logic [2:0] OP_SET_CURSOR = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_WRITE_CELL = 3'd4;
  localparam logic [2:0] OP_READ_CELL  = 3'd5;

  typedef struct packed {
    logic [2:0]       operation;
    logic [7:0]       char_code;
    logic [7:0]       attr;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [IDX_W-1:0] cell_index;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cursor_index;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             chars_printed;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } rsp_item_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_CHAR,
    K_NEWLINE,
    K_BACKSPACE,
    K_COLOR,
    K_CURSOR,
    K_CLEAR,
    K_WRITE,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       chr;
    logic [7:0]       attr;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tcw_cmd_t;

endpackage

>>> rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tcw_front.sv
// Front end: accepts command items, decodes them into command kinds, queues them.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      q_valid,
  output tcw_cmd_t  q_head,
  input  logic      q_pop
);

  tcw_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  tcw_cmd_t   dec;
  logic       push;
  logic [31:0] target;

  assign target = 32'(cmd.row) * 32'(COLS) + 32'(cmd.col);

  always_comb begin
    dec      = '0;
    dec.kind = K_NONE;
    dec.chr  = cmd.char_code;
    dec.attr = cmd.attr;
    dec.idx  = cmd.cell_index;
    dec.row  = ROW_W'(cmd.row);
    dec.col  = COL_W'(cmd.col);
    unique case (cmd.operation)
      OP_PUT_CHAR: begin
        if (cmd.char_code == CH_NEWLINE) begin
          dec.kind = K_NEWLINE;
        end else if (cmd.char_code == CH_BACKSPACE) begin
          dec.kind = K_BACKSPACE;
        end else begin
          dec.kind = K_CHAR;
        end
      end
      OP_SET_COLOR: dec.kind = K_COLOR;
      OP_SET_CURSOR: begin
        if (int'(cmd.row) < ROWS && int'(cmd.col) < COLS) begin
          dec.kind = K_CURSOR;
          dec.idx  = IDX_W'(target);
        end
      end
      OP_CLEAR: dec.kind = K_CLEAR;
      OP_WRITE_CELL: begin
        if (int'(cmd.cell_index) < CELLS) begin
          dec.kind = K_WRITE;
        end
      end
      OP_READ_CELL: begin
        if (int'(cmd.cell_index) < CELLS) begin
          dec.kind = K_READ;
        end
      end
      default: dec.kind = K_NONE;
    endcase
  end

  assign cmd_ready = (count != 2'd2);
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (count != 2'd0);
  assign q_head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/tcw_back.sv
// Back end: executes decoded commands against the cell store, cursor and color.
// Runs the reset fill, clear fill and scroll copy; holds the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  tcw_cmd_t  q_head,
  output logic      q_pop,
  input  logic [7:0] blank_attr,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

  localparam logic [IDX_W-1:0] LAST_CELL  = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] LAST_ROW0  = IDX_W'(CELLS - COLS);
  localparam logic [IDX_W-1:0] COLS_IDX   = IDX_W'(COLS);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLS - 1);

  state_t           st, st_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [7:0]       color, color_next;
  logic [7:0]       fill_attr, fill_attr_next;
  logic             fill_report, fill_report_next;
  logic             printed, printed_next;
  logic             rsp_valid_next;
  rsp_item_t        rsp_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [CELL_W-1:0] rdata;

  logic             out_free;
  logic             report_now;
  logic [IDX_W-1:0] bs_idx;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS),
    .AW    (IDX_W)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !rsp_valid || rsp_ready;
  assign bs_idx   = (cur_idx == '0) ? '0 : cur_idx - IDX_W'(1);

  always_comb begin
    st_next          = st;
    cnt_next         = cnt;
    cur_idx_next     = cur_idx;
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    color_next       = color;
    fill_attr_next   = fill_attr;
    fill_report_next = fill_report;
    printed_next     = printed;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    rsp_next         = rsp;
    report_now       = 1'b0;
    q_pop            = 1'b0;
    we               = 1'b0;
    waddr            = cnt;
    wdata            = {fill_attr, CH_SPACE};
    re               = 1'b0;
    raddr            = cnt + COLS_IDX;

    unique case (st)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop        = 1'b1;
          report_now   = 1'b1;
          printed_next = 1'b0;
          unique case (q_head.kind)
            K_CHAR: begin
              we           = 1'b1;
              waddr        = cur_idx;
              wdata        = {color, q_head.chr};
              printed_next = 1'b1;
              cur_idx_next = cur_idx + IDX_W'(1);
              if (cur_col == LAST_COL) begin
                cur_col_next = '0;
                if (cur_row == LAST_ROW) begin
                  cur_idx_next   = LAST_ROW0;
                  st_next        = ST_SCROLL;
                  cnt_next       = '0;
                  fill_attr_next = blank_attr;
                  report_now     = 1'b0;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
              end else begin
                cur_col_next = cur_col + COL_W'(1);
              end
            end
            K_NEWLINE: begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                cur_idx_next   = LAST_ROW0;
                st_next        = ST_SCROLL;
                cnt_next       = '0;
                fill_attr_next = blank_attr;
                report_now     = 1'b0;
              end else begin
                cur_row_next = cur_row + ROW_W'(1);
                cur_idx_next = cur_idx + COLS_IDX - IDX_W'(cur_col);
              end
            end
            K_BACKSPACE: begin
              we           = 1'b1;
              waddr        = bs_idx;
              wdata        = {blank_attr, CH_SPACE};
              cur_idx_next = bs_idx;
              if (cur_col != '0) begin
                cur_col_next = cur_col - COL_W'(1);
              end else if (cur_row != '0) begin
                cur_row_next = cur_row - ROW_W'(1);
                cur_col_next = LAST_COL;
              end
            end
            K_COLOR: color_next = q_head.attr;
            K_CURSOR: begin
              cur_idx_next = q_head.idx;
              cur_row_next = q_head.row;
              cur_col_next = q_head.col;
            end
            K_CLEAR: begin
              cur_idx_next     = '0;
              cur_row_next     = '0;
              cur_col_next     = '0;
              color_next       = blank_attr;
              fill_attr_next   = blank_attr;
              fill_report_next = 1'b1;
              cnt_next         = '0;
              st_next          = ST_FILL;
              report_now       = 1'b0;
            end
            K_WRITE: begin
              we    = 1'b1;
              waddr = q_head.idx;
              wdata = {q_head.attr, q_head.chr};
            end
            K_READ: begin
              re         = 1'b1;
              raddr      = q_head.idx;
              st_next    = ST_READ;
              report_now = 1'b0;
            end
            default: ;
          endcase
          if (report_now) begin
            rsp_valid_next         = 1'b1;
            rsp_next.cursor_index  = cur_idx_next;
            rsp_next.cursor_row    = cur_row_next;
            rsp_next.cursor_col    = cur_col_next;
            rsp_next.chars_printed = printed_next;
            rsp_next.cell_char     = '0;
            rsp_next.cell_attr     = '0;
          end
        end
      end
      ST_READ: begin
        rsp_valid_next         = 1'b1;
        rsp_next.cursor_index  = cur_idx;
        rsp_next.cursor_row    = cur_row;
        rsp_next.cursor_col    = cur_col;
        rsp_next.chars_printed = 1'b0;
        rsp_next.cell_char     = rdata[7:0];
        rsp_next.cell_attr     = rdata[15:8];
        st_next                = ST_IDLE;
      end
      ST_SCROLL: begin
        re    = (cnt < LAST_ROW0);
        we    = (cnt != '0);
        waddr = cnt - IDX_W'(1);
        wdata = rdata;
        if (cnt == LAST_ROW0) begin
          fill_report_next = 1'b1;
          st_next          = ST_FILL;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt == LAST_CELL) begin
          st_next = ST_IDLE;
          if (fill_report) begin
            rsp_valid_next         = 1'b1;
            rsp_next.cursor_index  = cur_idx;
            rsp_next.cursor_row    = cur_row;
            rsp_next.cursor_col    = cur_col;
            rsp_next.chars_printed = printed;
            rsp_next.cell_char     = '0;
            rsp_next.cell_attr     = '0;
          end
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp     <= rsp_next;
    printed <= printed_next;
    if (rst) begin
      st          <= ST_FILL;
      cnt         <= '0;
      cur_idx     <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      color       <= BLANK_ATTR_RESET;
      fill_attr   <= BLANK_ATTR_RESET;
      fill_report <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      st          <= st_next;
      cnt         <= cnt_next;
      cur_idx     <= cur_idx_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      color       <= color_next;
      fill_attr   <= fill_attr_next;
      fill_report <= fill_report_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

endmodule

>>> rtl/text_console_writer_unit.sv
// Top level of the text console writer: config register, front decode queue, back executor.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// cmd      | cmd_valid/cmd_ready  | cmd_item_t: operation, char, attr, row, col, cell
// rsp      | rsp_valid/rsp_ready  | rsp_item_t: cursor, printed flag, cell read back
// apb      | psel/penable/pready  | blank_attr at byte addresses 0-3
//
// Most items are executed in the idle state; a cell read also passes through the read state.
// Clear runs the fill state, a scroll the scroll then fill states: one cell per cycle
// through the single write port of the cell store.
// After reset a fill pass blanks the store; commands queue meanwhile.
// The two-entry command queue accepts until full while the executor works or rsp stalls.
module text_console_writer_unit import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_item_t          cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_item_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       blank_attr;
  logic [7:0] blank_attr_q;
  logic       q_valid;
  logic       q_pop;
  tcw_cmd_t   q_head;

  assign pready     = 1'b1;
  assign blank_attr = (paddr[PADDR_W-1] == REG_BLANK_ATTR);
  assign prdata     = blank_attr ? {24'b0, blank_attr_q} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr_q <= BLANK_ATTR_RESET;
    end else if (psel && penable && pwrite && blank_attr) begin
      blank_attr_q <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .blank_attr (blank_attr_q),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
